// ----- rtl/core/assert_macros.svh -----
// Concurrent assertion helpers, clocked on clk with arst_n as the disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/kps_pkg.sv -----
package kps_pkg;

	localparam int unsigned KPS_RESULT_DEPTH = 4;

	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_TICK  = 8'h27;
	localparam logic [7:0] CHAR_M     = 8'h6D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [31:0] HARDENED_BIT = 32'h8000_0000;

	typedef enum logic [2:0] {
		PH_EMPTY  = 3'd0,
		PH_M      = 3'd1,
		PH_DIGITS = 3'd2,
		PH_TICK   = 3'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_ELEMENT = 2'd0,
		ST_OK      = 2'd1,
		ST_REJECT  = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] element;
		status_t     status;
		logic        last;
	} result_t;

	// Results raised by one character: count, then up to two words in order.
	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
	} parse_out_t;

endpackage

// ----- rtl/core/kps_if.sv -----
interface kps_path_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_mark;

	modport source (output valid, output char_code, output end_mark, input ready);
	modport sink (input valid, input char_code, input end_mark, output ready);
endinterface

interface kps_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] element;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, output element, output status, output last, input ready);
	modport sink (input valid, input element, input status, input last, output ready);
endinterface

// ----- rtl/core/keypath_string_parser.sv -----
// A character's first result word passes the input stage and then the result queue before it can be taken.
// Throughput: one character per cycle while the queue has room; an end marker closing
// a pending element yields two words, delivered in order from the result queue.
// Input stalls only while the result queue holds fewer than two free entries.
// Reset: arst_n asynchronously empties the input stage and queue and restarts the parser.
module keypath_string_parser
	import kps_pkg::*;
#(
	parameter int unsigned RESULT_DEPTH = KPS_RESULT_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	kps_path_if.sink     path,
	kps_result_if.source result
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;
	logic       fire;
	logic       has_room;
	parse_out_t parsed;
	result_t    head;

	assign fire       = valid_s1 && has_room;
	assign path.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (path.ready) begin
			valid_s1 <= path.valid;
		end
	end

	// hold the payload while the stage waits for queue room
	always_ff @(posedge clk) begin
		if (path.valid && path.ready) begin
			char_s1 <= path.char_code;
			end_s1  <= path.end_mark;
		end
	end

	kps_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.char_code (char_s1),
		.end_mark  (end_s1),
		.res       (parsed)
	);

	parse_out_t push;
	always_comb begin
		push       = parsed;
		push.count = fire ? parsed.count : 2'd0;
	end

	kps_fifo #(
		.DEPTH (RESULT_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (result.ready),
		.has_room (has_room),
		.valid    (result.valid),
		.head     (head)
	);

	assign result.element = head.element;
	assign result.status  = head.status;
	assign result.last    = head.last;

endmodule

// ----- rtl/core/kps_parse.sv -----
`include "assert_macros.svh"

module kps_parse
	import kps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] char_code,
	input  logic       end_mark,
	output parse_out_t res
);

	phase_t      phase_q, phase_d;
	logic [31:0] acc_q, acc_d;
	logic        first_q, first_d;
	logic        failed_q, failed_d;

	logic [35:0] acc_x10;
	logic        is_digit;
	logic        pending;
	logic [31:0] item_val;
	result_t     elem_res;
	result_t     stat_res;

	assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, char_code[3:0]};
	assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
	assign pending  = !failed_q && ((phase_q == PH_DIGITS) || (phase_q == PH_TICK));
	assign item_val = (phase_q == PH_TICK) ? (acc_q | HARDENED_BIT) : acc_q;

	always_comb begin
		elem_res.element = item_val;
		elem_res.status  = ST_ELEMENT;
		elem_res.last    = 1'b0;
		stat_res.element = 32'd0;
		stat_res.status  = failed_q ? ST_REJECT : ST_OK;
		stat_res.last    = 1'b1;
	end

	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		first_d    = first_q;
		failed_d   = failed_q;
		res.count  = 2'd0;
		res.res0   = elem_res;
		res.res1   = stat_res;
		if (end_mark) begin
			// return to the start-of-string state
			phase_d  = PH_EMPTY;
			acc_d    = 32'd0;
			first_d  = 1'b1;
			failed_d = 1'b0;
			if (pending) begin
				res.count = 2'd2;
			end else begin
				res.count = 2'd1;
				res.res0  = stat_res;
			end
		end else if (!failed_q) begin
			if (char_code == CHAR_SLASH) begin
				if (phase_q == PH_EMPTY) begin
					failed_d = 1'b1;
				end else begin
					if (pending) begin
						res.count = 2'd1;
					end
					first_d = 1'b0;
					phase_d = PH_EMPTY;
					acc_d   = 32'd0;
				end
			end else if (is_digit) begin
				if ((phase_q == PH_EMPTY) || (phase_q == PH_DIGITS)) begin
					if (|acc_x10[35:32]) begin
						failed_d = 1'b1;
					end else begin
						acc_d   = acc_x10[31:0];
						phase_d = PH_DIGITS;
					end
				end else begin
					failed_d = 1'b1;
				end
			end else if (char_code == CHAR_TICK) begin
				if (phase_q == PH_DIGITS) begin
					phase_d = PH_TICK;
				end else begin
					failed_d = 1'b1;
				end
			end else if (char_code == CHAR_M) begin
				if ((phase_q == PH_EMPTY) && first_q) begin
					phase_d = PH_M;
				end else begin
					failed_d = 1'b1;
				end
			end else begin
				failed_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_EMPTY;
			acc_q    <= 32'd0;
			first_q  <= 1'b1;
			failed_q <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			first_q  <= first_d;
			failed_q <= failed_d;
		end
	end

	`ASSERT_IMPLIES(a_no_elem_after_fail, fire && failed_q && !end_mark, res.count == 2'd0, "element after rejection")
	`ASSERT_NEXT(a_end_restarts, fire && end_mark, (phase_q == PH_EMPTY) && first_q && !failed_q, "end marker did not restart")
	`ASSERT_IMPLIES(a_m_only_first, phase_q == PH_M, first_q && (acc_q == 32'd0), "m item outside first place")

endmodule

// ----- rtl/core/kps_fifo.sv -----
`include "assert_macros.svh"

module kps_fifo
	import kps_pkg::*;
#(
	parameter int unsigned DEPTH = KPS_RESULT_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  parse_out_t push,
	input  logic       pop,
	output logic       has_room,
	output logic       valid,
	output result_t    head
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	result_t        mem [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  count_q;
	logic [AW-1:0]  wr_next;
	logic           do_pop;

	function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	assign wr_next  = advance(wr_q);
	assign valid    = (count_q != '0);
	assign do_pop   = pop && valid;
	assign has_room = (count_q <= CW'(DEPTH - 2));
	assign head     = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.res0;
		end
		if (push.count == 2'd2) begin
			mem[wr_next] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			case (push.count)
				2'd1:    wr_q <= wr_next;
				2'd2:    wr_q <= advance(wr_next);
				default: wr_q <= wr_q;
			endcase
			if (do_pop) begin
				rd_q <= advance(rd_q);
			end
			count_q <= count_q + CW'(push.count) - CW'(do_pop);
		end
	end

	`ASSERT_ALWAYS(a_count_bound, count_q <= CW'(DEPTH), "result queue overrun")
	`ASSERT_IMPLIES(a_push_room, push.count != 2'd0, has_room, "push without room")
	`ASSERT_NEXT(a_pop_only, do_pop && (push.count == 2'd0), $past(count_q) == count_q + 1'b1, "pop count slip")

endmodule

// ----- tb/sv/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kps_pkg::*;

	localparam int STALL_MAX    = 19;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int TARGET_WORDS = 1500;

	typedef logic [7:0] char_q_t[$];

	// Tracks the parse of the current path and the result words it must produce.
	class path_scoreboard;
		phase_t      phase;
		logic [31:0] acc;
		bit          first_item;
		bit          failed;
		result_t     pending_results[$];
		int          mismatches;
		int          words_seen;

		function new();
			restart();
			mismatches = 0;
			words_seen = 0;
		endfunction

		function void restart();
			phase      = PH_EMPTY;
			acc        = '0;
			first_item = 1'b1;
			failed     = 1'b0;
		endfunction

		function logic [31:0] item_value();
			return (phase == PH_TICK) ? (acc | HARDENED_BIT) : acc;
		endfunction

		function void push_result(logic [31:0] element, status_t status, logic last);
			result_t r;
			r.element = element;
			r.status  = status;
			r.last    = last;
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void parse_word(logic [7:0] ch, logic end_mark);
			logic [63:0] wide;
			if (end_mark) begin
				if (!failed && (phase == PH_DIGITS || phase == PH_TICK))
					push_result(item_value(), ST_ELEMENT, 1'b0);
				if (failed)
					push_result('0, ST_REJECT, 1'b1);
				else
					push_result('0, ST_OK, 1'b1);
				restart();
				return;
			end
			if (failed)
				return;
			if (ch == CHAR_SLASH) begin
				if (phase == PH_EMPTY) begin
					failed = 1'b1;
				end else begin
					if (phase == PH_DIGITS || phase == PH_TICK)
						push_result(item_value(), ST_ELEMENT, 1'b0);
					first_item = 1'b0;
					phase      = PH_EMPTY;
					acc        = '0;
				end
			end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
				if (phase == PH_EMPTY || phase == PH_DIGITS) begin
					wide = 64'(acc) * 64'd10 + 64'(ch - CHAR_ZERO);
					// reject on the digit that pushes the value past 32 bits
					if (wide > 64'hFFFF_FFFF) begin
						failed = 1'b1;
					end else begin
						acc   = wide[31:0];
						phase = PH_DIGITS;
					end
				end else begin
					failed = 1'b1;
				end
			end else if (ch == CHAR_TICK) begin
				if (phase == PH_DIGITS)
					phase = PH_TICK;
				else
					failed = 1'b1;
			end else if (ch == CHAR_M) begin
				if (phase == PH_EMPTY && first_item)
					phase = PH_M;
				else
					failed = 1'b1;
			end else begin
				failed = 1'b1;
			end
		endfunction

		task report(string what);
			$display("[%0t] result word %0d: %s", $time, words_seen, what);
			mismatches++;
		endtask

		task check_result(logic [31:0] element, logic [1:0] status, logic last);
			result_t want;
			words_seen++;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected word element=%h status=%0d last=%0d",
					element, status, last));
				return;
			end
			want = pending_results.pop_front();
			if (element !== want.element)
				report($sformatf("element %h, want %h", element, want.element));
			if (status !== want.status)
				report($sformatf("status %0d, want %s", status, want.status.name()));
			if (last !== want.last)
				report($sformatf("last %0d, want %0d", last, want.last));
		endtask

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int   words_sent;
	int   quiet_cycles;

	string directed_paths[$] = '{"", "/", "m/0'/", "1''", "m1", "4294967295'", "4294967296"};

	path_scoreboard path_sb = new();

	kps_path_if   path_ch();
	kps_result_if result_ch();

	keypath_string_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.path(path_ch),
		.result(result_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int draw_wait();
		if (calm)
			return 0;
		return $urandom_range(0, STALL_MAX);
	endfunction

	function automatic void append_text(ref char_q_t q, input string s);
		for (int i = 0; i < s.len(); i++)
			q.insert(q.size(), s[i]);
	endfunction

	function automatic char_q_t random_path();
		char_q_t         q;
		int              n_el;
		bit              broken;
		bit              lead_m;
		longint unsigned v;
		logic [7:0]      extra;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6))
				q.insert(q.size(), 8'($urandom_range(0, 255)));
			return q;
		end
		broken = ($urandom_range(0, 3) == 0);
		lead_m = $urandom_range(0, 1);
		n_el   = $urandom_range(0, 5);
		if (lead_m)
			q.insert(q.size(), CHAR_M);
		for (int k = 0; k < n_el; k++) begin
			if (lead_m || k > 0)
				q.insert(q.size(), CHAR_SLASH);
			if (broken && $urandom_range(0, 2) == 0) begin
				v = 64'd4294967296 + longint'($urandom);
			end else begin
				case ($urandom_range(0, 5))
					0: v = $urandom_range(0, 9);
					1: v = $urandom_range(10, 999);
					2: v = $urandom;
					3: v = 64'hFFFF_FFFF;
					4: v = 64'h8000_0000 | longint'($urandom);
					default: v = 64'h7FFF_FFFF + $urandom_range(0, 1);
				endcase
			end
			if ($urandom_range(0, 7) == 0)
				append_text(q, "00");
			append_text(q, $sformatf("%0d", v));
			if ($urandom_range(0, 1))
				q.insert(q.size(), CHAR_TICK);
		end
		if ((lead_m || n_el > 0) && $urandom_range(0, 3) == 0)
			q.insert(q.size(), CHAR_SLASH);
		if (broken) begin
			case ($urandom_range(0, 4))
				0: extra = CHAR_SLASH;
				1: extra = CHAR_M;
				2: extra = CHAR_TICK;
				3: extra = CHAR_ZERO + 8'($urandom_range(0, 9));
				default: extra = 8'($urandom_range(0, 255));
			endcase
			q.insert($urandom_range(0, q.size()), extra);
		end
		return q;
	endfunction

	// Hold valid and the word until the handshake; drop valid only across a gap.
	task automatic send_word(input logic [7:0] ch, input logic end_mark);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			path_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		path_ch.valid     <= 1'b1;
		path_ch.char_code <= ch;
		path_ch.end_mark  <= end_mark;
		do @(posedge clk); while (!(path_ch.valid && path_ch.ready));
	endtask

	task automatic send_path(input char_q_t chars);
		foreach (chars[i])
			send_word(chars[i], 1'b0);
		send_word(8'($urandom_range(0, 255)), 1'b1);
		words_sent += chars.size() + 1;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (path_ch.valid && path_ch.ready)
				path_sb.parse_word(path_ch.char_code, path_ch.end_mark);
			if (result_ch.valid && result_ch.ready)
				path_sb.check_result(result_ch.element, result_ch.status, result_ch.last);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (path_ch.valid && path_ch.ready) ||
				(result_ch.valid && result_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
		end
	end

	initial begin
		char_q_t q;
		int      n_paths;
		arst_n            <= 1'b0;
		path_ch.valid     <= 1'b0;
		path_ch.char_code <= '0;
		path_ch.end_mark  <= 1'b0;
		calm       = 1'b0;
		words_sent = 0;
		n_paths    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_paths[i]) begin
			q.delete();
			append_text(q, directed_paths[i]);
			send_path(q);
		end
		q = '{8'hFF};
		send_path(q);

		while (words_sent < TARGET_WORDS) begin
			// switch between stretches with and without idling
			if (n_paths % 16 == 0)
				calm = ($urandom_range(0, 2) == 0);
			send_path(random_path());
			n_paths++;
		end
		path_ch.valid <= 1'b0;
		// let the monitor note the final end marker before counting what is owed
		@(posedge clk);

		while (path_sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (path_sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
